// ===== rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// types and codes shared by the i2c master transaction sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_EVENT = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    XFER_SEND      = 2'd0,
    XFER_RECV      = 2'd1,
    XFER_SEND_RECV = 2'd2,
    XFER_RECV_SEND = 2'd3
  } xfer_t;

  typedef enum logic [2:0] {
    KIND_IDLE      = 3'd0,
    KIND_SEND      = 3'd1,
    KIND_RECV      = 3'd2,
    KIND_SEND_RECV = 3'd3,
    KIND_RECV_SEND = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_ACK     = 3'd4,
    CMD_NACK    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    EV_START       = 4'd0,
    EV_RESTART     = 4'd1,
    EV_ADDR_W_ACK  = 4'd2,
    EV_ADDR_W_NACK = 4'd3,
    EV_DATA_TX_ACK = 4'd4,
    EV_DATA_TX_NACK = 4'd5,
    EV_ADDR_R_ACK  = 4'd6,
    EV_ADDR_R_NACK = 4'd7,
    EV_DATA_RX_ACK = 4'd8,
    EV_DATA_RX_NACK = 4'd9
  } event_t;

  // read address bit set on the address byte
  localparam logic [7:0] ADDR_READ_BIT = 8'h01;
  localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] transfer_kind;
    logic [6:0] target_address;
    logic [5:0] tx_length;
    logic [5:0] rx_length;
    logic [4:0] buffer_index;
    logic [7:0] tx_byte;
    logic [3:0] event_code;
    logic [7:0] bus_data;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic       write_valid;
    logic [7:0] write_byte;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       start_error;
    logic [3:0] event_echo;
  } result_t;

  typedef struct packed {
    kind_t      current_kind;
    logic [5:0] byte_position;
    logic [7:0] address_byte;
    logic [5:0] send_count;
    logic [5:0] receive_count;
    logic       stop_pending;
    logic       restart_pending;
    logic       nack_next;
    logic       busy_flag;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{
    current_kind:    KIND_IDLE,
    byte_position:   6'd0,
    address_byte:    8'd0,
    send_count:      6'd0,
    receive_count:   6'd0,
    stop_pending:    1'b0,
    restart_pending: 1'b0,
    nack_next:       1'b0,
    busy_flag:       1'b0
  };

  // write request from the control logic into one of the byte stores
  typedef struct packed {
    logic       en;
    logic [5:0] pos;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ===== rtl/i2cms_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_in_if
// request channel: valid, ready and one input item
// ----------------------------------------------------------------------------
interface i2cms_in_if import i2cms_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cms_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_out_if
// response channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface i2cms_out_if import i2cms_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cms_store.sv =====
// ----------------------------------------------------------------------------
// i2cms_store
// byte store, one write port, one registered read port with write bypass
// ----------------------------------------------------------------------------
module i2cms_store #(
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [7:0]                              wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [7:0]                              rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-edge write wins so the read sees the new byte
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== rtl/i2cms_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cms_ctrl
// next state, store writes and result for the item in the input register
// ----------------------------------------------------------------------------
module i2cms_ctrl import i2cms_pkg::*; #(
  parameter int BUFFER_BYTES = 32
) (
  input  seq_state_t st,
  input  item_t      item,
  input  logic [7:0] tx_rd,
  input  logic [7:0] rx_rd,
  output seq_state_t st_next,
  output result_t    res,
  output store_wr_t  tx_wr,
  output store_wr_t  rx_wr
);

  logic [5:0] bp_inc;
  logic [6:0] bp_plus1;
  logic [6:0] bp_plus2;
  logic [6:0] rc_ext;
  logic       need_tx;
  logic       need_rx;
  logic       too_long;
  logic       rd_kind;
  logic       bp_in_range;
  logic       idx_in_range;

  assign bp_inc       = st.byte_position + 6'd1;
  assign bp_plus1     = {1'b0, st.byte_position} + 7'd1;
  assign bp_plus2     = {1'b0, bp_inc} + 7'd1;
  assign rc_ext       = {1'b0, st.receive_count};
  assign bp_in_range  = int'(st.byte_position) < BUFFER_BYTES;
  assign idx_in_range = int'(item.buffer_index) < BUFFER_BYTES;
  assign need_tx      = item.transfer_kind != XFER_RECV;
  assign need_rx      = item.transfer_kind != XFER_SEND;
  assign too_long     = (need_tx && (int'(item.tx_length) > BUFFER_BYTES)) ||
                        (need_rx && (int'(item.rx_length) > BUFFER_BYTES));
  assign rd_kind      = (item.transfer_kind == XFER_RECV) ||
                        (item.transfer_kind == XFER_RECV_SEND);

  always_comb begin
    st_next    = st;
    res        = '0;
    tx_wr      = '0;
    rx_wr      = '0;
    tx_wr.pos  = {1'b0, item.buffer_index};
    tx_wr.data = item.tx_byte;
    rx_wr.pos  = st.byte_position;
    rx_wr.data = item.bus_data;

    unique case (item.mode)
      MODE_LOAD: begin
        tx_wr.en = idx_in_range;
      end
      MODE_READ: begin
        res.rx_byte = idx_in_range ? rx_rd : 8'd0;
      end
      MODE_START: begin
        if (too_long) begin
          res.start_error = 1'b1;
        end else begin
          st_next.current_kind    = kind_t'({1'b0, item.transfer_kind} + 3'd1);
          st_next.send_count      = item.tx_length;
          st_next.receive_count   = item.rx_length;
          st_next.byte_position   = 6'd0;
          st_next.busy_flag       = 1'b1;
          st_next.stop_pending    = 1'b0;
          st_next.restart_pending = 1'b0;
          st_next.nack_next       = 1'b0;
          st_next.address_byte    = {item.target_address, rd_kind};
          res.bus_command         = CMD_START;
        end
      end
      default: begin
        res.event_echo = item.event_code;
        unique case (item.event_code)
          EV_START: begin
            res.write_valid = 1'b1;
            res.write_byte  = st.address_byte;
          end
          EV_RESTART: begin
            if (st.current_kind == KIND_RECV_SEND) begin
              st_next.byte_position = 6'd0;
              st_next.current_kind  = KIND_SEND;
              st_next.nack_next     = 1'b0;
              res.write_valid       = 1'b1;
              res.write_byte        = st.address_byte & ADDR_WRITE_MASK;
            end else if (st.current_kind == KIND_SEND_RECV) begin
              st_next.byte_position = 6'd0;
              st_next.current_kind  = KIND_RECV;
              st_next.nack_next     = 1'b0;
              res.write_valid       = 1'b1;
              res.write_byte        = st.address_byte | ADDR_READ_BIT;
            end else begin
              st_next.stop_pending = 1'b1;
            end
          end
          EV_ADDR_W_ACK, EV_DATA_TX_ACK: begin
            if (st.byte_position >= st.send_count) begin
              if (st.current_kind == KIND_SEND_RECV) begin
                st_next.restart_pending = 1'b1;
              end else begin
                st_next.stop_pending = 1'b1;
              end
            end else begin
              res.write_valid       = 1'b1;
              res.write_byte        = bp_in_range ? tx_rd : 8'd0;
              st_next.byte_position = bp_inc;
            end
          end
          EV_ADDR_R_ACK: begin
            if (bp_plus1 >= rc_ext) begin
              st_next.nack_next = 1'b1;
            end
          end
          EV_DATA_RX_ACK: begin
            if (st.byte_position >= st.receive_count) begin
              // overrun: the byte at the exact end is still kept
              if (st.byte_position == st.receive_count) begin
                rx_wr.en              = bp_in_range;
                st_next.byte_position = bp_inc;
              end
              st_next.stop_pending = 1'b1;
            end else begin
              rx_wr.en              = bp_in_range;
              st_next.byte_position = bp_inc;
              if (bp_plus2 >= rc_ext) begin
                st_next.nack_next = 1'b1;
              end
            end
          end
          EV_DATA_RX_NACK: begin
            rx_wr.en = bp_in_range;
            if (st.current_kind == KIND_RECV_SEND) begin
              st_next.restart_pending = 1'b1;
            end else begin
              st_next.stop_pending = 1'b1;
            end
          end
          default: begin
            st_next.stop_pending = 1'b1;
          end
        endcase

        priority if (st_next.restart_pending) begin
          res.bus_command         = CMD_RESTART;
          st_next.restart_pending = 1'b0;
        end else if (st_next.stop_pending) begin
          res.bus_command   = CMD_STOP;
          st_next.busy_flag = 1'b0;
        end else begin
          res.bus_command = st_next.nack_next ? CMD_NACK : CMD_ACK;
        end
      end
    endcase

    res.busy_res = st_next.busy_flag;
  end

endmodule

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// sequences i2c master transactions over a byte-level bus core
// ----------------------------------------------------------------------------
// path: a request passes the input register, then the result register; the
//   response is valid once the item reaches the result register
// throughput: one beat per cycle while the response side takes its beats
// reset: synchronous, active high; clears both stages and the sequencer state,
//   byte stores keep their contents and are undefined until written
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer import i2cms_pkg::*; #(
  parameter int BUFFER_BYTES = 32
) (
  input logic         clk,
  input logic         rst,
  i2cms_in_if.sink    req,
  i2cms_out_if.source rsp
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  // input register stage
  logic       s1_valid;
  item_t      s1_item;
  logic       s1_advance;
  logic       req_acc;

  // sequencer state and result register
  seq_state_t st;
  seq_state_t st_next;
  result_t    res;
  logic       out_valid;
  result_t    out_res;

  // store traffic
  store_wr_t  tx_wr;
  store_wr_t  rx_wr;
  logic [7:0] tx_rd;
  logic [7:0] rx_rd;
  logic [5:0] bp_commit;

  // the item in s1 moves on when the result register is empty or draining
  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign req_acc    = req.valid && req.ready;

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_res;

  // byte position as it stands after this edge; tx_rd always tracks the
  // transmit byte at the current position, so a send event needs no extra read
  assign bp_commit  = s1_advance ? st_next.byte_position : st.byte_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= SEQ_RESET;
    end else begin
      if (req_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_item <= req.data;
    end
    if (s1_advance) begin
      out_res <= res;
    end
  end

  i2cms_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .st      (st),
    .item    (s1_item),
    .tx_rd   (tx_rd),
    .rx_rd   (rx_rd),
    .st_next (st_next),
    .res     (res),
    .tx_wr   (tx_wr),
    .rx_wr   (rx_wr)
  );

  // transmit store: loaded by load beats, read at the byte position
  i2cms_store #(
    .DEPTH(BUFFER_BYTES)
  ) u_tx_store (
    .clk   (clk),
    .we    (s1_advance && tx_wr.en),
    .waddr (AW'(tx_wr.pos)),
    .wdata (tx_wr.data),
    .re    (1'b1),
    .raddr (AW'(bp_commit)),
    .rdata (tx_rd)
  );

  // receive store: filled by data events, read when a read beat is taken
  i2cms_store #(
    .DEPTH(BUFFER_BYTES)
  ) u_rx_store (
    .clk   (clk),
    .we    (s1_advance && rx_wr.en),
    .waddr (AW'(rx_wr.pos)),
    .wdata (rx_wr.data),
    .re    (req_acc),
    .raddr (AW'(req.data.buffer_index)),
    .rdata (rx_rd)
  );

  // sequencer state only moves when an item leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(s1_advance)) |-> (st == $past(st)))
    else $error("sequencer state changed without an item");

  // a stop answer always ends the transaction
  a_stop_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.bus_command == CMD_STOP)) |-> !out_res.busy_res)
    else $error("stop answered while still busy");

  // a rejected start issues no bus command
  a_start_error_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.start_error) |-> (out_res.bus_command == CMD_NONE))
    else $error("start error with a bus command");

  // an accepted start leaves the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && (res.bus_command == CMD_START)) |=> st.busy_flag)
    else $error("start accepted but not busy");

endmodule
